[hw/rtl/lcdw_pkg.sv]
// ----------------------------------------------------------------------------
// lcdw_pkg
// Types and constants shared by the character display write encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  // display width in characters
  localparam int COLUMNS = 16;

  // cursor column holds go-to targets up to 63 and print positions up to COLUMNS
  localparam int CURSOR_W = 6;
  localparam logic [CURSOR_W-1:0] COLUMNS_C = CURSOR_W'(COLUMNS);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [7:0] CMD_LINE1_OFS = 8'h40;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] NIBBLE_MASK   = 8'hF0;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_RAW   = 2'd1,
    OP_GOTO  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  value;
    logic [5:0]  column;
    logic        row;
  } req_t;

  typedef struct packed {
    logic [7:0]  bus_value;
    logic        reg_select;
    logic        last;
  } wr_t;

  // one classified request: optional wrap command, then the main byte
  typedef struct packed {
    logic        has_pre;
    logic [7:0]  pre_byte;
    logic [7:0]  main_byte;
    logic        main_rs;
  } entry_t;

  typedef struct packed {
    logic        full;
    logic        empty;
  } qstat_t;

endpackage

`default_nettype wire

[hw/rtl/char_lcd_write_with_cursor_wrap.sv]
// ----------------------------------------------------------------------------
// char_lcd_write_with_cursor_wrap
// Turns display requests into register-select tagged bus writes.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   lcdw_pkg::req_t (op, value, column, row)
//   wr       out  wr_valid/wr_stall     lcdw_pkg::wr_t (bus_value, reg_select, last)
//   cfg      in   cfg_we                cfg_data (bus_mode)
//
// One bus write leaves per cycle from the back sequencer while the queue is not
// empty and the output is not stalled; a request takes 1 to 4 writes: 1 per byte
// in eight-bit mode, 2 per byte in four-bit mode, plus one byte for a wrapping
// print. The front classifies a request in the cycle it is accepted and queues
// it two deep; a stalled output holds the sequencer and later the queue.
// Synchronous reset clears cursor, queue, output valid; bus_mode to eight-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_with_cursor_wrap (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire lcdw_pkg::req_t  req,
  output logic                 wr_valid,
  input  wire logic            wr_stall,
  output lcdw_pkg::wr_t        wr,
  input  wire logic            cfg_we,
  input  wire logic            cfg_data
);

  logic              bus_mode;
  logic              push;
  logic              pop;
  lcdw_pkg::entry_t  push_entry;
  lcdw_pkg::entry_t  head;
  lcdw_pkg::qstat_t  qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b0;
    end else if (cfg_we) begin
      bus_mode <= cfg_data;
    end
  end

  lcdw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .push       (push),
    .push_entry (push_entry),
    .qstat      (qstat)
  );

  lcdw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  lcdw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .bus_mode (bus_mode),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr       (wr)
  );

`ifndef ASSERT_OFF
  a_qstat_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_nibble_low_zero: assert property (@(posedge clk) disable iff (rst)
    (bus_mode && wr_valid) |-> (wr.bus_value[3:0] == 4'b0000))
    else $error("four-bit write carries low nibble bits");
`endif

endmodule

`default_nettype wire

[hw/rtl/lcdw_front.sv]
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts requests, tracks the cursor and turns each request into an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire lcdw_pkg::req_t  req,
  output logic                 push,
  output lcdw_pkg::entry_t     push_entry,
  input  wire lcdw_pkg::qstat_t qstat
);

  logic [lcdw_pkg::CURSOR_W-1:0] cursor_column, cursor_column_next;
  logic                          cursor_row, cursor_row_next;
  logic                          wrap;

  assign req_stall = qstat.full;
  assign push      = req_valid && !qstat.full;
  assign wrap      = cursor_column >= lcdw_pkg::COLUMNS_C;

  always_comb begin
    push_entry         = '0;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    unique case (req.op)
      lcdw_pkg::OP_PRINT: begin
        push_entry.has_pre   = wrap;
        // wrap moves to column 0 of the other line
        push_entry.pre_byte  = cursor_row ? lcdw_pkg::CMD_SET_ADDR
                                          : (lcdw_pkg::CMD_SET_ADDR | lcdw_pkg::CMD_LINE1_OFS);
        push_entry.main_byte = req.value;
        push_entry.main_rs   = lcdw_pkg::RS_DATA;
        if (wrap) begin
          cursor_column_next = lcdw_pkg::CURSOR_W'(1);
          cursor_row_next    = !cursor_row;
        end else begin
          cursor_column_next = cursor_column + lcdw_pkg::CURSOR_W'(1);
        end
      end
      lcdw_pkg::OP_RAW: begin
        push_entry.main_byte = req.value;
        push_entry.main_rs   = lcdw_pkg::RS_COMMAND;
      end
      lcdw_pkg::OP_GOTO: begin
        push_entry.main_byte = {1'b1, req.row, req.column};
        push_entry.main_rs   = lcdw_pkg::RS_COMMAND;
        cursor_column_next   = lcdw_pkg::CURSOR_W'(req.column);
        cursor_row_next      = req.row;
      end
      lcdw_pkg::OP_CLEAR: begin
        push_entry.main_byte = lcdw_pkg::CMD_CLEAR;
        push_entry.main_rs   = lcdw_pkg::RS_COMMAND;
        cursor_column_next   = '0;
        cursor_row_next      = 1'b0;
      end
      default: begin
        push_entry = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= 1'b0;
    end else if (push) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lcdw_queue.sv]
// ----------------------------------------------------------------------------
// lcdw_queue
// Short first-in first-out queue of classified entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lcdw_pkg::entry_t push_entry,
  input  wire logic             pop,
  output lcdw_pkg::entry_t      head,
  output lcdw_pkg::qstat_t      qstat
);

  lcdw_pkg::entry_t                slots [lcdw_pkg::QUEUE_DEPTH];
  logic [lcdw_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [lcdw_pkg::QCNT_W-1:0]     count;

  assign qstat.full  = count == lcdw_pkg::QCNT_W'(lcdw_pkg::QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign head        = slots[rd_ptr];

  function automatic logic [lcdw_pkg::QPTR_W-1:0] bump(input logic [lcdw_pkg::QPTR_W-1:0] p);
    if (p == lcdw_pkg::QPTR_W'(lcdw_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + lcdw_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + lcdw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - lcdw_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lcdw_back.sv]
// ----------------------------------------------------------------------------
// lcdw_back
// Sequences the bus writes of the head entry into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             bus_mode,
  input  wire lcdw_pkg::entry_t head,
  input  wire lcdw_pkg::qstat_t qstat,
  output logic                  pop,
  output logic                  wr_valid,
  input  wire logic             wr_stall,
  output lcdw_pkg::wr_t         wr
);

  logic        pre_done;
  logic        low_half;
  logic        on_pre;
  logic        load;
  logic [7:0]  cur_byte;
  lcdw_pkg::wr_t next_wr;

  assign on_pre   = head.has_pre && !pre_done;
  assign cur_byte = on_pre ? head.pre_byte : head.main_byte;
  assign load     = !qstat.empty && (!wr_valid || !wr_stall);

  always_comb begin
    next_wr.reg_select = on_pre ? lcdw_pkg::RS_COMMAND : head.main_rs;
    if (!bus_mode) begin
      next_wr.bus_value = cur_byte;
    end else if (low_half) begin
      next_wr.bus_value = {cur_byte[3:0], 4'b0000};
    end else begin
      next_wr.bus_value = cur_byte & lcdw_pkg::NIBBLE_MASK;
    end
    next_wr.last = !on_pre && (!bus_mode || low_half);
  end

  assign pop = load && next_wr.last;

  always_ff @(posedge clk) begin
    if (load) begin
      wr <= next_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
      pre_done <= 1'b0;
      low_half <= 1'b0;
    end else begin
      if (load) begin
        wr_valid <= 1'b1;
        if (next_wr.last) begin
          pre_done <= 1'b0;
          low_half <= 1'b0;
        end else if (bus_mode && !low_half) begin
          low_half <= 1'b1;
        end else begin
          // wrap command finished, main byte next
          pre_done <= 1'b1;
          low_half <= 1'b0;
        end
      end else if (!wr_stall) begin
        wr_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
